FILE: rtl/gpa_pkg.sv
// ============================================================================
// gpa_pkg
// Shared types, constants and helpers for the grouped slot pool allocator.
// ============================================================================
package gpa_pkg;

  // Default sizes of the pool and of the group table
  localparam int unsigned POOL_SLOTS_DEF  = 1024;
  localparam int unsigned GROUP_COUNT_DEF = 8;

  // Field widths on the stream channels
  localparam int unsigned FUNC_W      = 1;
  localparam int unsigned GROUP_W     = 3;
  localparam int unsigned TIME_W      = 16;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned SLOT_OUT_W  = 10;
  localparam int unsigned FREED_W     = 11;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 24;

  // Operation codes carried in the input tuser
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_PAUSED = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_TGRP,
    S_TEVAL,
    S_TPUSH,
    S_RESP
  } state_e;

  // One result item
  typedef struct packed {
    status_e                 status;
    logic [SLOT_OUT_W-1:0]   slot;
    logic [FREED_W-1:0]      freed;
  } result_t;

  // Write strobes of the link memories
  typedef struct packed {
    logic next_we;
    logic prev_we;
  } link_wr_t;

  // Write strobes of the age and lifespan memories
  typedef struct packed {
    logic age_we;
    logic life_we;
  } slot_wr_t;

  // Reduce a group number modulo the number of groups by repeated subtraction
  function automatic logic [GROUP_W-1:0] reduce_group(input logic [GROUP_W-1:0] grp,
                                                      input int unsigned        count);
    logic [GROUP_W-1:0] r;
    r = grp;
    for (int i = 0; i < (1 << GROUP_W); i++) begin
      if (int'(r) >= count) begin
        r = r - GROUP_W'(count);
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/gpa_link_mem.sv
// ============================================================================
// gpa_link_mem
// Next and previous link memories, one shared read address, registered read.
// ============================================================================
module gpa_link_mem #(
  parameter int unsigned POOL_SLOTS = gpa_pkg::POOL_SLOTS_DEF,
  localparam int unsigned SLOT_W    = $clog2(POOL_SLOTS),
  localparam int unsigned LINK_W    = SLOT_W + 1
) (
  input  logic                clk_i,
  input  logic [SLOT_W-1:0]   rd_addr_i,
  output logic [LINK_W-1:0]   next_rd_o,
  output logic [LINK_W-1:0]   prev_rd_o,
  input  gpa_pkg::link_wr_t   wr_i,
  input  logic [SLOT_W-1:0]   next_waddr_i,
  input  logic [LINK_W-1:0]   next_wdata_i,
  input  logic [SLOT_W-1:0]   prev_waddr_i,
  input  logic [LINK_W-1:0]   prev_wdata_i
);
  import gpa_pkg::*;

  logic [LINK_W-1:0] next_mem [POOL_SLOTS];
  logic [LINK_W-1:0] prev_mem [POOL_SLOTS];

  // Write the forward links
  always_ff @(posedge clk_i) begin
    if (wr_i.next_we) begin
      next_mem[next_waddr_i] <= next_wdata_i;
    end
  end

  // Write the backward links
  always_ff @(posedge clk_i) begin
    if (wr_i.prev_we) begin
      prev_mem[prev_waddr_i] <= prev_wdata_i;
    end
  end

  // Registered read of both links
  always_ff @(posedge clk_i) begin
    next_rd_o <= next_mem[rd_addr_i];
    prev_rd_o <= prev_mem[rd_addr_i];
  end

endmodule

FILE: rtl/gpa_slot_mem.sv
// ============================================================================
// gpa_slot_mem
// Age and lifespan memories of the slots, registered read.
// ============================================================================
module gpa_slot_mem #(
  parameter int unsigned POOL_SLOTS = gpa_pkg::POOL_SLOTS_DEF,
  localparam int unsigned SLOT_W    = $clog2(POOL_SLOTS)
) (
  input  logic                        clk_i,
  input  logic [SLOT_W-1:0]           rd_addr_i,
  output logic [gpa_pkg::TIME_W-1:0]  age_rd_o,
  output logic [gpa_pkg::TIME_W-1:0]  life_rd_o,
  input  gpa_pkg::slot_wr_t           wr_i,
  input  logic [SLOT_W-1:0]           waddr_i,
  input  logic [gpa_pkg::TIME_W-1:0]  age_wdata_i,
  input  logic [gpa_pkg::TIME_W-1:0]  life_wdata_i
);
  import gpa_pkg::*;

  logic [TIME_W-1:0] age_mem  [POOL_SLOTS];
  logic [TIME_W-1:0] life_mem [POOL_SLOTS];

  // Write age and lifespan
  always_ff @(posedge clk_i) begin
    if (wr_i.age_we) begin
      age_mem[waddr_i] <= age_wdata_i;
    end
    if (wr_i.life_we) begin
      life_mem[waddr_i] <= life_wdata_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    age_rd_o  <= age_mem[rd_addr_i];
    life_rd_o <= life_mem[rd_addr_i];
  end

endmodule

FILE: rtl/gpa_ctrl.sv
// ============================================================================
// gpa_ctrl
// Sequencer: list heads, free head, fill mark and the read-modify-write walk.
// ============================================================================
module gpa_ctrl #(
  parameter int unsigned POOL_SLOTS  = gpa_pkg::POOL_SLOTS_DEF,
  parameter int unsigned GROUP_COUNT = gpa_pkg::GROUP_COUNT_DEF,
  localparam int unsigned SLOT_W     = $clog2(POOL_SLOTS),
  localparam int unsigned LINK_W     = SLOT_W + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [gpa_pkg::FUNC_W-1:0]  in_func_i,
  input  logic [gpa_pkg::GROUP_W-1:0] in_group_i,
  input  logic [gpa_pkg::TIME_W-1:0]  in_lifespan_i,
  input  logic [gpa_pkg::TIME_W-1:0]  in_elapsed_i,
  input  logic                        paused_i,
  input  logic                        out_free_i,
  output logic                        res_valid_o,
  output gpa_pkg::result_t            res_o,
  // link memory
  output logic [SLOT_W-1:0]           rd_addr_o,
  input  logic [LINK_W-1:0]           next_rd_i,
  input  logic [LINK_W-1:0]           prev_rd_i,
  output gpa_pkg::link_wr_t           link_wr_o,
  output logic [SLOT_W-1:0]           next_waddr_o,
  output logic [LINK_W-1:0]           next_wdata_o,
  output logic [SLOT_W-1:0]           prev_waddr_o,
  output logic [LINK_W-1:0]           prev_wdata_o,
  // age and lifespan memory
  input  logic [gpa_pkg::TIME_W-1:0]  age_rd_i,
  input  logic [gpa_pkg::TIME_W-1:0]  life_rd_i,
  output gpa_pkg::slot_wr_t           slot_wr_o,
  output logic [SLOT_W-1:0]           slot_waddr_o,
  output logic [gpa_pkg::TIME_W-1:0]  age_wdata_o,
  output logic [gpa_pkg::TIME_W-1:0]  life_wdata_o
);
  import gpa_pkg::*;

  localparam int unsigned GRP_W = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
  localparam int unsigned CNT_W = SLOT_W + 1;
  localparam logic [LINK_W-1:0] LINK_NULL = {1'b1, {SLOT_W{1'b0}}};
  localparam logic [GRP_W-1:0]  GRP_LAST  = GRP_W'(GROUP_COUNT - 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(POOL_SLOTS - 1);

  state_e              state_q, state_d;
  logic [LINK_W-1:0]   free_head_q, free_head_d;
  logic [CNT_W-1:0]    fill_q, fill_d;
  logic [LINK_W-1:0]   ghead_q [GROUP_COUNT];
  logic [LINK_W-1:0]   ghead_d [GROUP_COUNT];
  logic [GRP_W-1:0]    grp_q, grp_d;
  logic [LINK_W-1:0]   cur_q, cur_d;
  logic [LINK_W-1:0]   nxt_q, nxt_d;
  logic [TIME_W-1:0]   life_q, life_d;
  logic [TIME_W-1:0]   dt_q, dt_d;
  logic [FREED_W-1:0]  freed_q, freed_d;
  status_e             status_q, status_d;
  logic [SLOT_OUT_W-1:0] slot_q, slot_d;
  logic [SLOT_W-1:0]   rd_addr_q;

  logic                accept;
  logic [LINK_W-1:0]   head_sel;
  logic [SLOT_W-1:0]   cur_idx;
  logic                untouched;
  logic [LINK_W-1:0]   init_next;
  logic [LINK_W-1:0]   next_eff;
  logic [LINK_W-1:0]   prev_eff;
  logic [TIME_W:0]     age_sum;
  logic [TIME_W-1:0]   age_new;
  logic                expired;
  logic                last_grp;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign head_sel   = ghead_q[grp_q];
  assign cur_idx    = cur_q[SLOT_W-1:0];
  assign last_grp   = (grp_q == GRP_LAST);

  // Slots at or above the fill mark were never written and keep the reset chain
  assign untouched = ({1'b0, rd_addr_q} >= fill_q);
  assign init_next = (rd_addr_q == SLOT_LAST) ? LINK_NULL
                                              : {1'b0, rd_addr_q + SLOT_W'(1)};
  assign next_eff  = untouched ? init_next : next_rd_i;

  // The list head has no predecessor whatever its stored link says
  assign prev_eff  = (cur_q == head_sel) ? LINK_NULL : prev_rd_i;

  // Saturating age update and expiry test
  assign age_sum = {1'b0, age_rd_i} + {1'b0, dt_q};
  assign age_new = age_sum[TIME_W] ? {TIME_W{1'b1}} : age_sum[TIME_W-1:0];
  assign expired = (age_new > life_rd_i);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (paused_i) begin
            state_d = S_RESP;
          end else if (in_func_i == FUNC_ALLOC) begin
            state_d = free_head_q[SLOT_W] ? S_RESP : S_ALLOC;
          end else begin
            state_d = S_TGRP;
          end
        end
      end
      S_ALLOC: begin
        state_d = S_RESP;
      end
      S_TGRP: begin
        if (!head_sel[SLOT_W]) begin
          state_d = S_TEVAL;
        end else if (last_grp) begin
          state_d = S_RESP;
        end
      end
      S_TEVAL: begin
        if (expired) begin
          state_d = S_TPUSH;
        end else if (!next_eff[SLOT_W]) begin
          state_d = S_TEVAL;
        end else begin
          state_d = last_grp ? S_RESP : S_TGRP;
        end
      end
      S_TPUSH: begin
        if (!nxt_q[SLOT_W]) begin
          state_d = S_TEVAL;
        end else begin
          state_d = last_grp ? S_RESP : S_TGRP;
        end
      end
      S_RESP: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Datapath, memory accesses and outputs
  always_comb begin
    free_head_d  = free_head_q;
    fill_d       = fill_q;
    ghead_d      = ghead_q;
    grp_d        = grp_q;
    cur_d        = cur_q;
    nxt_d        = nxt_q;
    life_d       = life_q;
    dt_d         = dt_q;
    freed_d      = freed_q;
    status_d     = status_q;
    slot_d       = slot_q;
    rd_addr_o    = free_head_q[SLOT_W-1:0];
    link_wr_o    = '0;
    next_waddr_o = cur_idx;
    next_wdata_o = free_head_q;
    prev_waddr_o = next_eff[SLOT_W-1:0];
    prev_wdata_o = prev_eff;
    slot_wr_o    = '0;
    slot_waddr_o = cur_idx;
    age_wdata_o  = age_new;
    life_wdata_o = life_q;
    res_valid_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        // Latch the item; the free head is being read already
        if (accept) begin
          cur_d    = free_head_q;
          life_d   = in_lifespan_i;
          dt_d     = in_elapsed_i;
          freed_d  = '0;
          slot_d   = '0;
          status_d = ST_DONE;
          grp_d    = (in_func_i == FUNC_ALLOC)
                     ? GRP_W'(reduce_group(in_group_i, GROUP_COUNT)) : '0;
          if (paused_i) begin
            status_d = ST_PAUSED;
          end else if (in_func_i == FUNC_ALLOC && free_head_q[SLOT_W]) begin
            status_d = ST_FULL;
          end
        end
      end
      S_ALLOC: begin
        // Pop the free head and push it at the head of its group
        free_head_d    = next_eff;
        ghead_d[grp_q] = cur_q;
        link_wr_o.next_we = 1'b1;
        next_waddr_o   = cur_idx;
        next_wdata_o   = head_sel;
        link_wr_o.prev_we = ~head_sel[SLOT_W];
        prev_waddr_o   = head_sel[SLOT_W-1:0];
        prev_wdata_o   = cur_q;
        slot_wr_o.age_we  = 1'b1;
        slot_wr_o.life_we = 1'b1;
        age_wdata_o    = '0;
        if (untouched) begin
          fill_d = fill_q + CNT_W'(1);
        end
        slot_d = SLOT_OUT_W'(cur_idx);
      end
      S_TGRP: begin
        // Start the walk of the current group, or skip an empty one
        rd_addr_o = head_sel[SLOT_W-1:0];
        if (!head_sel[SLOT_W]) begin
          cur_d = head_sel;
        end else if (!last_grp) begin
          grp_d = grp_q + GRP_W'(1);
        end
      end
      S_TEVAL: begin
        // Age the slot; unlink it if it has outlived its lifespan
        slot_wr_o.age_we = 1'b1;
        if (expired) begin
          freed_d = freed_q + FREED_W'(1);
          nxt_d   = next_eff;
          if (!prev_eff[SLOT_W]) begin
            link_wr_o.next_we = 1'b1;
            next_waddr_o      = prev_eff[SLOT_W-1:0];
            next_wdata_o      = next_eff;
          end else begin
            ghead_d[grp_q] = next_eff;
          end
          link_wr_o.prev_we = ~next_eff[SLOT_W];
        end else if (!next_eff[SLOT_W]) begin
          cur_d     = next_eff;
          rd_addr_o = next_eff[SLOT_W-1:0];
        end else if (!last_grp) begin
          grp_d = grp_q + GRP_W'(1);
        end
      end
      S_TPUSH: begin
        // Push the expired slot on the free list and move on
        link_wr_o.next_we = 1'b1;
        next_waddr_o      = cur_idx;
        next_wdata_o      = free_head_q;
        free_head_d       = cur_q;
        rd_addr_o         = nxt_q[SLOT_W-1:0];
        if (!nxt_q[SLOT_W]) begin
          cur_d = nxt_q;
        end else if (!last_grp) begin
          grp_d = grp_q + GRP_W'(1);
        end
      end
      S_RESP: begin
        res_valid_o = out_free_i;
      end
      default: begin
      end
    endcase
  end

  assign res_o = '{status: status_q, slot: slot_q, freed: freed_q};

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_head_q <= '0;
      fill_q      <= '0;
      for (int i = 0; i < GROUP_COUNT; i++) begin
        ghead_q[i] <= LINK_NULL;
      end
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      fill_q      <= fill_d;
      ghead_q     <= ghead_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    grp_q     <= grp_d;
    cur_q     <= cur_d;
    nxt_q     <= nxt_d;
    life_q    <= life_d;
    dt_q      <= dt_d;
    freed_q   <= freed_d;
    status_q  <= status_d;
    slot_q    <= slot_d;
    rd_addr_q <= rd_addr_o;
  end

endmodule

FILE: rtl/grouped_pool_allocator_with_aging.sv
// ============================================================================
// grouped_pool_allocator_with_aging
// Slot pool with a LIFO free list, per-group linked lists and lifetime aging.
// ============================================================================
// Usage:
//   Items enter on the s_axis channel; tuser selects allocate or tick, tdata
//   carries group, lifespan and elapsed time. Each item yields exactly one
//   transfer on m_axis: tuser is the status, tdata the slot and freed count.
//   The pause register is written over the cfg channel, which is always
//   ready; write it only while no item is in flight.
//   Sequence: an allocate passes through S_ALLOC and then S_RESP, a dropped
//   item goes straight to S_RESP, and a tick walks the groups in S_TGRP,
//   S_TEVAL and S_TPUSH, one slot at a time through the single read port of
//   the link memories, before S_RESP. In S_RESP the result waits until the
//   output register is free, is then loaded and offered on m_axis from then
//   on; s_axis_tready returns at the same edge, so the input takes no new
//   item until the result of the last one has been loaded.
//   While m_axis stalls, one result waits there and the block finishes the
//   following item, then holds until the register empties.
//   Reset empties every group, puts all slots on the free list in order
//   and clears the pause register; no clearing pass is needed.
// ============================================================================
module grouped_pool_allocator_with_aging #(
  parameter int unsigned POOL_SLOTS  = gpa_pkg::POOL_SLOTS_DEF,
  parameter int unsigned GROUP_COUNT = gpa_pkg::GROUP_COUNT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input items
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [gpa_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // group, lifespan, elapsed
  input  logic [gpa_pkg::FUNC_W-1:0]       s_axis_tuser,  // func
  // results
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [gpa_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // slot, freed_count
  output logic [gpa_pkg::STATUS_W-1:0]     m_axis_tuser,  // status
  // pause register
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic                             cfg_data_i
);
  import gpa_pkg::*;

  localparam int unsigned SLOT_W = $clog2(POOL_SLOTS);
  localparam int unsigned LINK_W = SLOT_W + 1;

  logic                 paused_q;
  logic                 m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q;
  logic [STATUS_W-1:0]  m_user_q;
  logic                 out_free;
  logic                 res_valid;
  result_t              res;

  logic [SLOT_W-1:0]    rd_addr;
  logic [LINK_W-1:0]    next_rd;
  logic [LINK_W-1:0]    prev_rd;
  link_wr_t             link_wr;
  logic [SLOT_W-1:0]    next_waddr;
  logic [LINK_W-1:0]    next_wdata;
  logic [SLOT_W-1:0]    prev_waddr;
  logic [LINK_W-1:0]    prev_wdata;
  logic [TIME_W-1:0]    age_rd;
  logic [TIME_W-1:0]    life_rd;
  slot_wr_t             slot_wr;
  logic [SLOT_W-1:0]    slot_waddr;
  logic [TIME_W-1:0]    age_wdata;
  logic [TIME_W-1:0]    life_wdata;

  // Pause register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paused_q <= 1'b0;
    end else if (cfg_valid_i) begin
      paused_q <= cfg_data_i;
    end
  end

  gpa_ctrl #(
    .POOL_SLOTS  (POOL_SLOTS),
    .GROUP_COUNT (GROUP_COUNT)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_func_i     (s_axis_tuser),
    .in_group_i    (s_axis_tdata[GROUP_W-1:0]),
    .in_lifespan_i (s_axis_tdata[GROUP_W +: TIME_W]),
    .in_elapsed_i  (s_axis_tdata[GROUP_W+TIME_W +: TIME_W]),
    .paused_i      (paused_q),
    .out_free_i    (out_free),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .rd_addr_o     (rd_addr),
    .next_rd_i     (next_rd),
    .prev_rd_i     (prev_rd),
    .link_wr_o     (link_wr),
    .next_waddr_o  (next_waddr),
    .next_wdata_o  (next_wdata),
    .prev_waddr_o  (prev_waddr),
    .prev_wdata_o  (prev_wdata),
    .age_rd_i      (age_rd),
    .life_rd_i     (life_rd),
    .slot_wr_o     (slot_wr),
    .slot_waddr_o  (slot_waddr),
    .age_wdata_o   (age_wdata),
    .life_wdata_o  (life_wdata)
  );

  gpa_link_mem #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_link_mem (
    .clk_i        (clk_i),
    .rd_addr_i    (rd_addr),
    .next_rd_o    (next_rd),
    .prev_rd_o    (prev_rd),
    .wr_i         (link_wr),
    .next_waddr_i (next_waddr),
    .next_wdata_i (next_wdata),
    .prev_waddr_i (prev_waddr),
    .prev_wdata_i (prev_wdata)
  );

  gpa_slot_mem #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_slot_mem (
    .clk_i        (clk_i),
    .rd_addr_i    (rd_addr),
    .age_rd_o     (age_rd),
    .life_rd_o    (life_rd),
    .wr_i         (slot_wr),
    .waddr_i      (slot_waddr),
    .age_wdata_i  (age_wdata),
    .life_wdata_i (life_wdata)
  );

  // Output register: hold a result until its transfer completes
  assign out_free = ~m_valid_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_valid) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      m_data_q <= OUT_TDATA_W'({res.freed, res.slot});
      m_user_q <= res.status;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

FILE: rtl/gpa_checker.sv
// ============================================================================
// gpa_checker
// Port-level checks of the slot pool allocator, bound to the top level.
// ============================================================================
module gpa_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [gpa_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic [gpa_pkg::STATUS_W-1:0]     m_axis_tuser
);
  import gpa_pkg::*;

  // A stalled result holds still
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A dropped item reports neither a slot nor a freed count
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_DONE |-> m_axis_tdata == '0)
    else $error("dropped item carries data");

  // An item either allocates or frees, never both
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[SLOT_OUT_W-1:0] == '0) ||
      (m_axis_tdata[SLOT_OUT_W +: FREED_W] == '0))
    else $error("slot and freed count both set");

  // The sequencer is busy in the cycle after it takes an item
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again right after a transfer");

endmodule

bind grouped_pool_allocator_with_aging gpa_checker u_gpa_checker (.*);

FILE: dv/tb_grouped_pool_allocator_with_aging.sv
// ============================================================================
// tb_grouped_pool_allocator_with_aging
// Self-checking bench for the grouped slot pool with lifetime aging.
// A short table of directed items (reset order, extremes, pause, saturation)
// is followed by phased random traffic that fills the pool to overflow and
// drains it again. Each result is checked against its row's expected result
// if typed, else a cycle-free predictor of free and group lists and ages.
// ============================================================================
module tb_grouped_pool_allocator_with_aging;
  import gpa_pkg::*;

  localparam int unsigned    SLOTS          = POOL_SLOTS_DEF;
  localparam int unsigned    GROUPS         = GROUP_COUNT_DEF;
  localparam logic [10:0]    LINK_NIL       = 11'h7FF;
  localparam int             QUIET_LIMIT    = 40000;
  localparam int             DRAIN_CYCLES   = 20;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  // One row of the directed stimulus table
  typedef struct {
    row_kind_e   kind;
    logic        cfg_val;
    logic        func;
    logic [2:0]  grp;
    logic [15:0] life;
    logic [15:0] dt;
    logic        typed;
    result_t     res;
  } plan_row_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [FUNC_W-1:0]      s_axis_tuser  = FUNC_ALLOC;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic                   cfg_data_i    = 1'b0;

  // Expectation carried alongside a directed item
  logic    drv_typed = 1'b0;
  result_t drv_exp   = '0;

  // Predictor state
  logic [10:0] nxt_link  [SLOTS];
  logic [10:0] prv_link  [SLOTS];
  logic [15:0] slot_age  [SLOTS];
  logic [15:0] slot_life [SLOTS];
  logic [10:0] grp_head  [GROUPS];
  logic [10:0] free_top;
  logic        pool_paused;
  int          free_cnt;

  result_t     pending_results [$];
  result_t     want_r;
  result_t     got_r;
  int          err_cnt       = 0;
  int          quiet_cycles  = 0;
  int          src_idle_pct  = 0;
  int          rcv_stall_pct = 0;
  plan_row_t   plan [20];

  grouped_pool_allocator_with_aging dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // group, lifespan, elapsed
    .s_axis_tuser  (s_axis_tuser),   // func
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // slot, freed_count
    .m_axis_tuser  (m_axis_tuser),   // status
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Generate the clock
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Stall the result side at random
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  // Advance the pool state by one item and return its result
  function automatic result_t predict_pool_result(input logic        func,
                                                  input logic [2:0]  grp,
                                                  input logic [15:0] life,
                                                  input logic [15:0] dt);
    result_t     r;
    logic [10:0] s;
    logic [10:0] nx;
    logic [10:0] pv;
    logic [10:0] nn;
    logic [16:0] a;
    int          guard;
    r = '0;
    r.status = ST_DONE;
    if (pool_paused) begin
      r.status = ST_PAUSED;
    end else if (func == FUNC_ALLOC) begin
      s = free_top;
      if (s >= SLOTS) begin
        r.status = ST_FULL;
      end else begin
        // pop the free head and push it on the group list
        free_top = nxt_link[s];
        if (free_top < SLOTS) prv_link[free_top] = LINK_NIL;
        prv_link[s] = LINK_NIL;
        nxt_link[s] = grp_head[grp];
        if (grp_head[grp] < SLOTS) prv_link[grp_head[grp]] = s;
        grp_head[grp] = s;
        slot_life[s]  = life;
        slot_age[s]   = '0;
        r.slot        = s[9:0];
        free_cnt      = free_cnt - 1;
      end
    end else begin
      // walk groups in ascending order, each from its head
      for (int g = 0; g < GROUPS; g++) begin
        s = grp_head[g];
        guard = 0;
        while (s < SLOTS && guard < SLOTS) begin
          nx = nxt_link[s];
          a  = {1'b0, slot_age[s]} + {1'b0, dt};
          if (a > 17'h0FFFF) a = 17'h0FFFF;
          slot_age[s] = a[15:0];
          if (a > {1'b0, slot_life[s]}) begin
            pv = prv_link[s];
            nn = nxt_link[s];
            if (pv < SLOTS) nxt_link[pv] = nn;
            else grp_head[g] = nn;
            if (nn < SLOTS) prv_link[nn] = pv;
            if (free_top < SLOTS) prv_link[free_top] = s;
            prv_link[s] = LINK_NIL;
            nxt_link[s] = free_top;
            free_top    = s;
            r.freed     = r.freed + 1'b1;
            free_cnt    = free_cnt + 1;
          end
          s = nx;
          guard++;
        end
      end
    end
    return r;
  endfunction

  // Check results, predict accepted items and count quiet cycles
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: tuser %0d tdata %h", m_axis_tuser, m_axis_tdata);
        err_cnt++;
      end else begin
        want_r = pending_results.pop_front();
        if (m_axis_tuser !== want_r.status) begin
          $error("status: expected %0d, got %0d", want_r.status, m_axis_tuser);
          err_cnt++;
        end
        if (m_axis_tdata[9:0] !== want_r.slot) begin
          $error("slot: expected %0d, got %0d", want_r.slot, m_axis_tdata[9:0]);
          err_cnt++;
        end
        if (m_axis_tdata[20:10] !== want_r.freed) begin
          $error("freed_count: expected %0d, got %0d", want_r.freed, m_axis_tdata[20:10]);
          err_cnt++;
        end
      end
    end
    if (s_axis_tvalid && s_axis_tready) begin
      got_r = predict_pool_result(s_axis_tuser[0], s_axis_tdata[2:0],
                                  s_axis_tdata[18:3], s_axis_tdata[34:19]);
      pending_results.push_back(drv_typed ? drv_exp : got_r);
    end
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // End the run if nothing moves for too long
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // Offer one item and hold it until the transfer; called at a falling edge
  task automatic push_item(input logic func, input logic [2:0] grp,
                           input logic [15:0] life, input logic [15:0] dt,
                           input logic typed, input result_t res);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {5'b0, dt, life, grp};
    drv_typed     <= typed;
    drv_exp       <= res;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Write the pause register once the block has gone idle
  task automatic write_pause(input logic val);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    pool_paused = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Send one random item; lifespans start at life_min, elapsed up to dt_max
  task automatic send_random(input int alloc_pct, input int life_min, input int dt_max);
    logic        f;
    logic [2:0]  g;
    logic [15:0] l;
    logic [15:0] d;
    int          k;
    k = $urandom_range(19);
    f = ($urandom_range(99) < alloc_pct) ? FUNC_ALLOC : FUNC_TICK;
    g = 3'($urandom_range(7));
    l = 16'($urandom_range(65535, life_min));
    if (k == 0) l = 16'hFFFF;
    if (k == 1 && life_min == 0) l = 16'h0000;
    d = (k == 2) ? 16'h0000 : 16'($urandom_range(dt_max));
    push_item(f, g, l, d, 1'b0, '0);
  endtask

  initial begin
    // reset state of the predictor: all slots free in order, groups empty
    for (int i = 0; i < SLOTS; i++) begin
      nxt_link[i]  = (i + 1 < SLOTS) ? 11'(i + 1) : LINK_NIL;
      prv_link[i]  = (i > 0) ? 11'(i - 1) : LINK_NIL;
      slot_age[i]  = '0;
      slot_life[i] = '0;
    end
    for (int i = 0; i < GROUPS; i++) grp_head[i] = LINK_NIL;
    free_top    = '0;
    pool_paused = 1'b0;
    free_cnt    = SLOTS;

    // directed rows: reset order, expiry, saturation, pause, ignored fields
    plan = '{
      '{ROW_ITEM, 1'b0, FUNC_ALLOC, 3'd0, 16'h0000, 16'h0000, 1'b1, '{ST_DONE, 10'd0, 11'd0}},
      '{ROW_ITEM, 1'b0, FUNC_ALLOC, 3'd7, 16'hFFFF, 16'h0000, 1'b1, '{ST_DONE, 10'd1, 11'd0}},
      '{ROW_ITEM, 1'b0, FUNC_ALLOC, 3'd3, 16'h1000, 16'hFFFF, 1'b1, '{ST_DONE, 10'd2, 11'd0}},
      '{ROW_ITEM, 1'b0, FUNC_TICK,  3'd0, 16'h0000, 16'h0000, 1'b1, '{ST_DONE, 10'd0, 11'd0}},
      '{ROW_ITEM, 1'b0, FUNC_TICK,  3'd7, 16'hFFFF, 16'h0001, 1'b1, '{ST_DONE, 10'd0, 11'd1}},
      '{ROW_ITEM, 1'b0, FUNC_ALLOC, 3'd5, 16'h8000, 16'h0000, 1'b1, '{ST_DONE, 10'd0, 11'd0}},
      '{ROW_ITEM, 1'b0, FUNC_TICK,  3'd0, 16'h0000, 16'hFFFF, 1'b1, '{ST_DONE, 10'd0, 11'd2}},
      '{ROW_ITEM, 1'b0, FUNC_TICK,  3'd0, 16'h0000, 16'hFFFF, 1'b1, '{ST_DONE, 10'd0, 11'd0}},
      '{ROW_CFG,  1'b1, FUNC_ALLOC, 3'd0, 16'h0000, 16'h0000, 1'b0, '0},
      '{ROW_ITEM, 1'b0, FUNC_ALLOC, 3'd2, 16'h1234, 16'h0000, 1'b1, '{ST_PAUSED, 10'd0, 11'd0}},
      '{ROW_ITEM, 1'b0, FUNC_TICK,  3'd7, 16'hFFFF, 16'hFFFF, 1'b1, '{ST_PAUSED, 10'd0, 11'd0}},
      '{ROW_CFG,  1'b0, FUNC_ALLOC, 3'd0, 16'h0000, 16'h0000, 1'b0, '0},
      '{ROW_ITEM, 1'b0, FUNC_ALLOC, 3'd4, 16'hABCD, 16'h5555, 1'b0, '0},
      '{ROW_ITEM, 1'b0, FUNC_ALLOC, 3'd6, 16'h0005, 16'h0000, 1'b0, '0},
      '{ROW_ITEM, 1'b0, FUNC_ALLOC, 3'd2, 16'h7FFF, 16'hAAAA, 1'b0, '0},
      '{ROW_ITEM, 1'b0, FUNC_ALLOC, 3'd1, 16'h0000, 16'h0000, 1'b0, '0},
      '{ROW_ITEM, 1'b0, FUNC_TICK,  3'd5, 16'h5A5A, 16'h0006, 1'b0, '0},
      '{ROW_ITEM, 1'b0, FUNC_TICK,  3'd0, 16'h0000, 16'h0000, 1'b0, '0},
      '{ROW_ITEM, 1'b0, FUNC_ALLOC, 3'd0, 16'hFFFF, 16'hFFFF, 1'b0, '0},
      '{ROW_ITEM, 1'b0, FUNC_TICK,  3'd7, 16'hFFFF, 16'h0010, 1'b0, '0}
    };

    // hold reset, then release at a falling edge
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // walk the directed table without idling
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_pause(plan[i].cfg_val);
      end else begin
        push_item(plan[i].func, plan[i].grp, plan[i].life, plan[i].dt,
                  plan[i].typed, plan[i].res);
      end
    end

    // mixed traffic with a stalling receiver
    rcv_stall_pct = 53;
    repeat (250) send_random(80, 0, 16'h0800);

    // paused: everything is dropped
    write_pause(1'b1);
    src_idle_pct  = 37;
    rcv_stall_pct = 37;
    repeat (40) send_random(60, 0, 16'hFFFF);
    write_pause(1'b0);

    // fill the pool with long-lived slots, then overflow it
    src_idle_pct  = 53;
    rcv_stall_pct = 0;
    while (free_cnt > 0) send_random(98, 16'hC000, 16);
    repeat (30) send_random(85, 16'hC000, 16);

    // drain with large elapsed times and no idling
    write_pause(1'b0);
    src_idle_pct = 0;
    repeat (250) send_random(50, 0, 16'hFFFF);

    // mixed traffic with both sides idling
    src_idle_pct  = 37;
    rcv_stall_pct = 37;
    repeat (300) send_random(70, 0, 16'h1000);
    s_axis_tvalid <= 1'b0;

    // let every result drain, then a few more cycles
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
